FILE: rtl/qrv_pkg.sv
// Shared types, widths and register codes for the quaternion rotation unit.
`timescale 1ns / 1ps

package qrv_pkg;

  // register and field widths
  localparam int REG_W              = 16;
  localparam int CFG_IDX_W          = 4;
  localparam int COORD_W            = 24;
  localparam int DEF_QUAT_FRAC_BITS = 14;

  // datapath widths, all exact
  localparam int PROD_W = COORD_W + REG_W;     // q * p product
  localparam int T_W    = PROD_W + 2;          // three-term sum of products
  localparam int LO_W   = 16;                  // low slice of t
  localparam int HI_W   = T_W - LO_W;          // high slice of t, signed
  localparam int COEF_W = REG_W + 1;           // conj coefficient, may be negated
  localparam int HP_W   = HI_W + COEF_W;       // high partial product
  localparam int LP_W   = LO_W + 1 + COEF_W;   // low partial product
  localparam int HS_W   = HP_W + 2;            // sum of four high products
  localparam int LS_W   = LP_W + 2;            // sum of four low products

  localparam int NUM_AXES  = 3;
  localparam int NUM_TERMS = 4;
  localparam int LAT       = 6;                // start to done, in cycles

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_REAL = 4'd0,
    REG_ROT_I    = 4'd1,
    REG_ROT_J    = 4'd2,
    REG_ROT_K    = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pt_x;
    logic signed [COORD_W-1:0] pt_y;
    logic signed [COORD_W-1:0] pt_z;
  } pt_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rot_x;
    logic signed [COORD_W-1:0] rot_y;
    logic signed [COORD_W-1:0] rot_z;
    logic                      clipped;
  } res_t;

  typedef struct packed {
    logic signed [REG_W-1:0] w;
    logic signed [REG_W-1:0] x;
    logic signed [REG_W-1:0] y;
    logic signed [REG_W-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [T_W-1:0] tw;
    logic signed [T_W-1:0] tx;
    logic signed [T_W-1:0] ty;
    logic signed [T_W-1:0] tz;
  } t_vec_t;

  typedef struct packed {
    logic signed [HS_W-1:0] hs;
    logic signed [LS_W-1:0] ls;
  } psum_t;

endpackage

FILE: rtl/qrv_tmul.sv
// First product stages: t = q * (0, p), products then three-term sums.
`timescale 1ns / 1ps

module qrv_tmul (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  qrv_pkg::pt_t   pt,
  input  qrv_pkg::quat_t quat,
  output logic           out_valid,
  output qrv_pkg::t_vec_t t
);
  import qrv_pkg::*;

  logic signed [REG_W-1:0]   qv [NUM_TERMS];
  logic signed [COORD_W-1:0] pv [NUM_AXES];
  logic signed [PROD_W-1:0]  prod [NUM_TERMS][NUM_AXES];
  logic                      v1;

  assign qv[0] = quat.w;
  assign qv[1] = quat.x;
  assign qv[2] = quat.y;
  assign qv[3] = quat.z;
  assign pv[0] = pt.pt_x;
  assign pv[1] = pt.pt_y;
  assign pv[2] = pt.pt_z;

  // stage 1: all twelve q component * p coordinate products
  always_ff @(posedge clk) begin
    for (int qi = 0; qi < NUM_TERMS; qi++) begin
      for (int pi = 0; pi < NUM_AXES; pi++) begin
        prod[qi][pi] <= PROD_W'(qv[qi]) * PROD_W'(pv[pi]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // stage 2: Hamilton product with a pure quaternion
  always_ff @(posedge clk) begin
    t.tw <= -(T_W'(prod[1][0]) + T_W'(prod[2][1]) + T_W'(prod[3][2]));
    t.tx <= T_W'(prod[0][0]) + T_W'(prod[2][2]) - T_W'(prod[3][1]);
    t.ty <= T_W'(prod[0][1]) + T_W'(prod[3][0]) - T_W'(prod[1][2]);
    t.tz <= T_W'(prod[0][2]) + T_W'(prod[1][1]) - T_W'(prod[2][0]);
  end

endmodule

FILE: rtl/qrv_cmul.sv
// Second product stages: t * conj(q), t split in high and low slices.
`timescale 1ns / 1ps

module qrv_cmul (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  qrv_pkg::t_vec_t t,
  input  qrv_pkg::quat_t quat,
  output logic           out_valid,
  output qrv_pkg::psum_t [qrv_pkg::NUM_AXES-1:0] psum
);
  import qrv_pkg::*;

  logic signed [T_W-1:0]    tv [NUM_TERMS];
  logic signed [HI_W-1:0]   th [NUM_TERMS];
  logic signed [LO_W:0]     tl [NUM_TERMS];
  logic signed [COEF_W-1:0] cf [NUM_AXES][NUM_TERMS];
  logic signed [COEF_W-1:0] cw, cx, cy, cz;
  logic signed [HP_W-1:0]   hp [NUM_AXES][NUM_TERMS];
  logic signed [LP_W-1:0]   lp [NUM_AXES][NUM_TERMS];
  logic                     v3;

  assign tv[0] = t.tw;
  assign tv[1] = t.tx;
  assign tv[2] = t.ty;
  assign tv[3] = t.tz;

  // t = th * 2^LO_W + tl, tl unsigned
  always_comb begin
    for (int m = 0; m < NUM_TERMS; m++) begin
      th[m] = $signed(tv[m][T_W-1:LO_W]);
      tl[m] = $signed({1'b0, tv[m][LO_W-1:0]});
    end
  end

  assign cw = COEF_W'(quat.w);
  assign cx = COEF_W'(quat.x);
  assign cy = COEF_W'(quat.y);
  assign cz = COEF_W'(quat.z);

  // coefficient of tw, tx, ty, tz for each output axis
  always_comb begin
    cf[0][0] = -cx; cf[0][1] = cw;  cf[0][2] = -cz; cf[0][3] = cy;
    cf[1][0] = -cy; cf[1][1] = cz;  cf[1][2] = cw;  cf[1][3] = -cx;
    cf[2][0] = -cz; cf[2][1] = -cy; cf[2][2] = cx;  cf[2][3] = cw;
  end

  // stage 3: partial products
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_AXES; k++) begin
      for (int m = 0; m < NUM_TERMS; m++) begin
        hp[k][m] <= HP_W'(th[m]) * HP_W'(cf[k][m]);
        lp[k][m] <= LP_W'(tl[m]) * LP_W'(cf[k][m]);
      end
    end
  end

  // stage 4: per-axis sums of high and low slices
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_AXES; k++) begin
      psum[k].hs <= HS_W'(hp[k][0]) + HS_W'(hp[k][1]) + HS_W'(hp[k][2]) + HS_W'(hp[k][3]);
      psum[k].ls <= LS_W'(lp[k][0]) + LS_W'(lp[k][1]) + LS_W'(lp[k][2]) + LS_W'(lp[k][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v3        <= in_valid;
      out_valid <= v3;
    end
  end

endmodule

FILE: rtl/qrv_round.sv
// Final stages: merge slices, round half up, shift and saturate.
`timescale 1ns / 1ps

module qrv_round #(
  parameter int QUAT_FRAC_BITS = qrv_pkg::DEF_QUAT_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  qrv_pkg::psum_t [qrv_pkg::NUM_AXES-1:0] psum,
  output logic         done,
  output qrv_pkg::res_t result
);
  import qrv_pkg::*;

  localparam int SHIFT = 2 * QUAT_FRAC_BITS;
  localparam int SUM_W = (HS_W + LO_W + 1 > SHIFT + 2) ? HS_W + LO_W + 1 : SHIFT + 2;
  localparam logic signed [SUM_W-1:0] RND  = SUM_W'(1) <<< (SHIFT - 1);
  localparam logic signed [SUM_W-1:0] MAXV =
    {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] MINV =
    {{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  logic signed [SUM_W-1:0]   sum [NUM_AXES];
  logic signed [SUM_W-1:0]   sh  [NUM_AXES];
  logic signed [COORD_W-1:0] r   [NUM_AXES];
  logic [NUM_AXES-1:0]       sat;
  logic                      v5;

  // stage 5: exact sum plus half an output LSB
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_AXES; k++) begin
      sum[k] <= (SUM_W'(psum[k].hs) <<< LO_W) + SUM_W'(psum[k].ls) + RND;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      sh[k]  = sum[k] >>> SHIFT;
      sat[k] = 1'b0;
      r[k]   = sh[k][COORD_W-1:0];
      if (sh[k] > MAXV) begin
        sat[k] = 1'b1;
        r[k]   = MAXV[COORD_W-1:0];
      end else if (sh[k] < MINV) begin
        sat[k] = 1'b1;
        r[k]   = MINV[COORD_W-1:0];
      end
    end
  end

  // stage 6: output word
  always_ff @(posedge clk) begin
    result.rot_x   <= r[0];
    result.rot_y   <= r[1];
    result.rot_z   <= r[2];
    result.clipped <= |sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v5   <= in_valid;
      done <= v5;
    end
  end

endmodule

FILE: rtl/quaternion_rotate_vector_unit.sv
// Top level of the quaternion point rotation unit.
`timescale 1ns / 1ps

// Rotates points by q * (0, p) * conj(q) and returns the vector part. A point
// word is taken on any clock where start is high and busy is low; busy is only
// high during reset, so one point per clock is accepted. The matching result
// word shows up on result with done high for exactly one cycle, in input
// order. The receiver cannot stall: done and result are not held, so a
// consumer must take them in that cycle. There are six register stages:
// q*p products, t sums, t*conj(q) partial products (t split into a signed
// high and unsigned low slice), slice sums, merge with rounding, and
// shift/saturate into the output register.
// Products are exact; the sum is rounded half up and shifted right by
// 2*QUAT_FRAC_BITS, then saturated to the coordinate width, with clipped set
// if any axis saturated. q is not normalized, so a non-unit q scales the
// result by |q|^2. The quaternion lives in four 16-bit registers written over
// the cfg port (index 0 real, 1 i, 2 j, 3 k; other indexes are ignored); reset
// loads the identity. Only write them while no point is in flight.
module quaternion_rotate_vector_unit #(
  parameter int QUAT_FRAC_BITS = qrv_pkg::DEF_QUAT_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  qrv_pkg::pt_t                   pt,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qrv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qrv_pkg::REG_W-1:0]      cfg_data,
  output logic                           done,
  output qrv_pkg::res_t                  result
);
  import qrv_pkg::*;

  localparam logic [REG_W-1:0] REAL_RESET = REG_W'(64'd1 << QUAT_FRAC_BITS);

  quat_t             rot_q;
  t_vec_t            t_vec;
  psum_t [NUM_AXES-1:0] psum;
  logic              t_valid;
  logic              ps_valid;
  logic              accept;

  // pipeline never backs up; only reset holds off new points
  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // orientation registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_q.w <= REAL_RESET;
      rot_q.x <= '0;
      rot_q.y <= '0;
      rot_q.z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROT_REAL: rot_q.w <= cfg_data;
        REG_ROT_I:    rot_q.x <= cfg_data;
        REG_ROT_J:    rot_q.y <= cfg_data;
        REG_ROT_K:    rot_q.z <= cfg_data;
        default: ;
      endcase
    end
  end

  // stages 1-2: t = q * p
  qrv_tmul u_tmul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .pt        (pt),
    .quat      (rot_q),
    .out_valid (t_valid),
    .t         (t_vec)
  );

  // stages 3-4: t * conj(q) partial sums
  qrv_cmul u_cmul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (t_valid),
    .t         (t_vec),
    .quat      (rot_q),
    .out_valid (ps_valid),
    .psum      (psum)
  );

  // stages 5-6: round, shift, saturate
  qrv_round #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_round (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ps_valid),
    .psum     (psum),
    .done     (done),
    .result   (result)
  );

  // every result word traces back to an accepted point, via $past(accept, LAT)
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result word without a matching point");

  a_cfg_real_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == REG_ROT_REAL |=> rot_q.w == $past(cfg_data))
    else $error("real part write not taken");

  a_cfg_bad_index: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index != REG_ROT_REAL && cfg_index != REG_ROT_I &&
    cfg_index != REG_ROT_J && cfg_index != REG_ROT_K |=> $stable(rot_q))
    else $error("write to unknown index changed the quaternion");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    done && result.clipped |->
      result.rot_x == {1'b0, {(COORD_W-1){1'b1}}} || result.rot_x == {1'b1, {(COORD_W-1){1'b0}}} ||
      result.rot_y == {1'b0, {(COORD_W-1){1'b1}}} || result.rot_y == {1'b1, {(COORD_W-1){1'b0}}} ||
      result.rot_z == {1'b0, {(COORD_W-1){1'b1}}} || result.rot_z == {1'b1, {(COORD_W-1){1'b0}}})
    else $error("clipped set but no axis at a limit");

endmodule
